// ----- sv/hsvc_pkg.sv -----
// Package for the HSV to RGBA converter: item types, fixed-point constants
// and hue sector codes. Depends on nothing; every module of the block imports it.
package hsvc_pkg;

   typedef struct packed {
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
      logic [7:0]  alpha_in;
   } hsv_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha_out;
   } rgba_item_type;

   typedef struct packed {
      logic [2:0] sector;
      logic [9:0] weight;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic [7:0] alpha;
   } class_item_type;

   localparam logic [12:0] HUE_FULL   = 13'd5760;
   localparam logic [9:0]  HUE_SECTOR = 10'd960;
   localparam logic [7:0]  FULL8      = 8'd255;
   localparam logic [17:0] X_DEN      = 18'd244800;

   localparam logic [9:0]  HUE_RECIP       = 10'd728;
   localparam int          HUE_RECIP_SHIFT = 22;
   localparam logic [15:0] Z_RECIP         = 16'd32897;
   localparam int          Z_RECIP_SHIFT   = 23;
   localparam logic [26:0] X_RECIP         = 27'd71863506;
   localparam int          X_RECIP_SHIFT   = 44;

   localparam logic [2:0] SECTOR_RED     = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN   = 3'd2;
   localparam logic [2:0] SECTOR_CYAN    = 3'd3;
   localparam logic [2:0] SECTOR_BLUE    = 3'd4;
   localparam logic [2:0] SECTOR_MAGENTA = 3'd5;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

endpackage

// ----- sv/hsvc_front.sv -----
// Front end of the HSV to RGBA converter: reduces the hue modulo a full turn
// and classifies it into a sector and a triangle weight. Uses hsvc_pkg.
module hsvc_front import hsvc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  hsv_item_type   in_data,
   input  logic           queue_full,
   output logic           busy,
   output logic           push,
   output class_item_type push_data
);

   logic           stall;
   logic           a_valid_ff, b_valid_ff, c_valid_ff;
   hsv_item_type   a_item_ff;
   logic [3:0]     a_quot_ff, a_quot_in;
   logic [25:0]    hue_prod;
   hsv_item_type   b_item_ff;
   logic [12:0]    b_hm_ff, b_hm_in;
   logic [16:0]    quot_times;
   logic [16:0]    hm_raw;
   class_item_type c_item_ff, c_item_in;
   logic [12:0]    sector_base;
   logic [9:0]     offset;

   assign stall = c_valid_ff && queue_full;
   assign busy  = stall;
   assign push  = c_valid_ff && !queue_full;
   assign push_data = c_item_ff;

   assign hue_prod  = in_data.hue * HUE_RECIP;
   assign a_quot_in = hue_prod[HUE_RECIP_SHIFT +: 4];

   assign quot_times = 17'(a_quot_ff) * 17'(HUE_FULL);
   assign hm_raw     = {1'b0, a_item_ff.hue} - quot_times;

   always_comb begin
      if (hm_raw >= 17'(HUE_FULL)) begin
         b_hm_in = hm_raw[12:0] - HUE_FULL;
      end else begin
         b_hm_in = hm_raw[12:0];
      end
   end

   always_comb begin
      if (b_hm_ff < 13'(HUE_SECTOR)) begin
         c_item_in.sector = SECTOR_RED;
         sector_base      = 13'd0;
      end else if (b_hm_ff < 13'(2 * HUE_SECTOR)) begin
         c_item_in.sector = SECTOR_YELLOW;
         sector_base      = 13'(HUE_SECTOR);
      end else if (b_hm_ff < 13'(3 * HUE_SECTOR)) begin
         c_item_in.sector = SECTOR_GREEN;
         sector_base      = 13'(2 * HUE_SECTOR);
      end else if (b_hm_ff < 13'(4 * HUE_SECTOR)) begin
         c_item_in.sector = SECTOR_CYAN;
         sector_base      = 13'(3 * HUE_SECTOR);
      end else if (b_hm_ff < 13'(5 * HUE_SECTOR)) begin
         c_item_in.sector = SECTOR_BLUE;
         sector_base      = 13'(4 * HUE_SECTOR);
      end else begin
         c_item_in.sector = SECTOR_MAGENTA;
         sector_base      = 13'(5 * HUE_SECTOR);
      end
      offset = 10'(b_hm_ff - sector_base);
      // Odd sectors fall towards the next primary, even sectors rise from one.
      if (c_item_in.sector[0]) begin
         c_item_in.weight = offset;
      end else begin
         c_item_in.weight = HUE_SECTOR - offset;
      end
      c_item_in.saturation = b_item_ff.saturation;
      c_item_in.brightness = b_item_ff.brightness;
      c_item_in.alpha      = b_item_ff.alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (!stall) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         a_item_ff <= in_data;
         a_quot_ff <= a_quot_in;
         b_item_ff <= a_item_ff;
         b_hm_ff   <= b_hm_in;
         c_item_ff <= c_item_in;
      end
   end

endmodule

// ----- sv/hsvc_queue.sv -----
// Short queue between the front and back ends of the HSV to RGBA converter.
// Holds classified items; uses hsvc_pkg for the item type.
module hsvc_queue import hsvc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  class_item_type push_data,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output class_item_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   class_item_type    store [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/hsvc_back.sv -----
// Back end of the HSV to RGBA converter: forms the zero and secondary
// channel levels in fixed point and places them by sector. Uses hsvc_pkg.
module hsvc_back import hsvc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  class_item_type in_data,
   output logic           out_valid,
   output rgba_item_type  out_data
);

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [17:0]   s1_prod_ff, s1_prod_in;
   logic [15:0]   s1_zero_ff, s1_zero_in;
   logic [7:0]    s1_val_ff, s1_alpha_ff, s2_val_ff, s2_alpha_ff;
   logic [2:0]    s1_sector_ff, s2_sector_ff;
   logic [17:0]   x_num;
   logic [25:0]   s2_xn_ff, s2_xn_in;
   logic [31:0]   zero_prod;
   logic [7:0]    s2_zq_ff, s2_zq_in;
   logic [52:0]   x_prod;
   logic [7:0]    x_level;
   rgba_item_type s3_item_ff, s3_item_in;

   assign s1_prod_in = 18'(in_data.saturation) * 18'(in_data.weight);
   assign s1_zero_in = 16'(in_data.brightness) * 16'(FULL8 - in_data.saturation);

   assign x_num     = X_DEN - s1_prod_ff;
   assign s2_xn_in  = 26'(s1_val_ff) * 26'(x_num);
   assign zero_prod = 32'(s1_zero_ff) * 32'(Z_RECIP);
   assign s2_zq_in  = zero_prod[Z_RECIP_SHIFT +: 8];

   assign x_prod  = 53'(s2_xn_ff) * 53'(X_RECIP);
   assign x_level = x_prod[X_RECIP_SHIFT +: 8];

   always_comb begin
      s3_item_in.alpha_out = s2_alpha_ff;
      case (s2_sector_ff)
         SECTOR_RED: begin
            s3_item_in.red   = s2_val_ff;
            s3_item_in.green = x_level;
            s3_item_in.blue  = s2_zq_ff;
         end
         SECTOR_YELLOW: begin
            s3_item_in.red   = x_level;
            s3_item_in.green = s2_val_ff;
            s3_item_in.blue  = s2_zq_ff;
         end
         SECTOR_GREEN: begin
            s3_item_in.red   = s2_zq_ff;
            s3_item_in.green = s2_val_ff;
            s3_item_in.blue  = x_level;
         end
         SECTOR_CYAN: begin
            s3_item_in.red   = s2_zq_ff;
            s3_item_in.green = x_level;
            s3_item_in.blue  = s2_val_ff;
         end
         SECTOR_BLUE: begin
            s3_item_in.red   = x_level;
            s3_item_in.green = s2_zq_ff;
            s3_item_in.blue  = s2_val_ff;
         end
         default: begin
            s3_item_in.red   = s2_val_ff;
            s3_item_in.green = s2_zq_ff;
            s3_item_in.blue  = x_level;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff   <= s1_prod_in;
      s1_zero_ff   <= s1_zero_in;
      s1_val_ff    <= in_data.brightness;
      s1_alpha_ff  <= in_data.alpha;
      s1_sector_ff <= in_data.sector;
      s2_xn_ff     <= s2_xn_in;
      s2_zq_ff     <= s2_zq_in;
      s2_val_ff    <= s1_val_ff;
      s2_alpha_ff  <= s1_alpha_ff;
      s2_sector_ff <= s1_sector_ff;
      s3_item_ff   <= s3_item_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_item_ff;

endmodule

// ----- sv/hsv_to_rgba_converter_unit.sv -----
// Top level of the HSV to RGBA converter: front end, queue and back end.
// Depends on hsvc_pkg, hsvc_front, hsvc_queue and hsvc_back.
//
//   channel   ports                       direction  transfer
//   request   start, busy, req_data       in         start high and busy low
//   response  rsp_valid, rsp_data         out        one-cycle strobe, no hold-off
//
// One item is accepted per clock while busy is low. The result passes through
// three front stages, the queue and three back stages: the two multiplier
// stages and the output register.
// Reset clears the valid flags of every stage and empties the queue.
// The back end never stalls, so busy stays low unless QUEUE_DEPTH is one.
module hsv_to_rgba_converter_unit import hsvc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  hsv_item_type  req_data,
   output logic          rsp_valid,
   output rgba_item_type rsp_data
);

   logic           front_push;
   class_item_type front_data;
   logic           queue_full;
   logic           queue_not_empty;
   class_item_type queue_data;

   hsvc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_data    (req_data),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (front_push),
      .push_data  (front_data)
   );

   hsvc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .pop       (queue_not_empty),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop_data  (queue_data)
   );

   hsvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_not_empty),
      .in_data   (queue_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for hsv_to_rgba_converter_unit. It converts each accepted colour
// in its own scoreboard class and compares every returned RGBA item field by field.
// Depends on hsvc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
   import hsvc_pkg::*;

   class colour_scoreboard;
      rgba_item_type pending[$];
      int unsigned   mismatches;
      int unsigned   checked;

      function rgba_item_type hsv_to_rgba(hsv_item_type c);
         rgba_item_type o;
         int unsigned   hm, t, span, k, full_ch, zero_ch, x_ch;
         logic [2:0]    sector;
         hm      = c.hue % 5760;
         sector  = 3'(hm / 960);
         t       = hm % 1920;
         span    = (t >= 960) ? (t - 960) : (960 - t);
         k       = 960 - span;
         full_ch = c.brightness;
         zero_ch = (c.brightness * (255 - c.saturation)) / 255;
         x_ch    = (c.brightness * (244800 - c.saturation * (960 - k))) / 244800;
         case (sector)
            SECTOR_RED: begin
               o.red = 8'(full_ch); o.green = 8'(x_ch); o.blue = 8'(zero_ch);
            end
            SECTOR_YELLOW: begin
               o.red = 8'(x_ch); o.green = 8'(full_ch); o.blue = 8'(zero_ch);
            end
            SECTOR_GREEN: begin
               o.red = 8'(zero_ch); o.green = 8'(full_ch); o.blue = 8'(x_ch);
            end
            SECTOR_CYAN: begin
               o.red = 8'(zero_ch); o.green = 8'(x_ch); o.blue = 8'(full_ch);
            end
            SECTOR_BLUE: begin
               o.red = 8'(x_ch); o.green = 8'(zero_ch); o.blue = 8'(full_ch);
            end
            default: begin
               o.red = 8'(full_ch); o.green = 8'(zero_ch); o.blue = 8'(x_ch);
            end
         endcase
         o.alpha_out = c.alpha_in;
         return o;
      endfunction

      function void note_colour(hsv_item_type c);
         pending = {pending, hsv_to_rgba(c)};
      endfunction

      function void check_colour(rgba_item_type got);
         rgba_item_type want;
         if (pending.size() == 0) begin
            $error("RGBA item arrived with no colour pending: %h", got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            mismatches++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            mismatches++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            mismatches++;
         end
         if (got.alpha_out !== want.alpha_out) begin
            $error("alpha_out: expected %0d, actual %0d", want.alpha_out, got.alpha_out);
            mismatches++;
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   hsv_item_type  req_data = '0;
   logic          rsp_valid;
   rgba_item_type rsp_data;

   colour_scoreboard sb = new();

   hsv_to_rgba_converter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1ns clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_colour(rsp_data);
   end

   task automatic send_colour(input hsv_item_type c);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (busy);
      sb.note_colour(c);
   endtask

   task automatic idle_cycles(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain_colours();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_hue();
      int unsigned base;
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 5759));
         2: begin
            base = $urandom_range(1, 68) * 960;
            return 16'(base - 1 + $urandom_range(0, 2));
         end
         default: return 16'($urandom_range(5760, 65535));
      endcase
   endfunction

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      hsv_item_type c;
      int unsigned  wait_cycles;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_colour('{16'd0,     8'd255, 8'd255, 8'd255});
      send_colour('{16'd0,     8'd0,   8'd0,   8'd0});
      send_colour('{16'd959,   8'd255, 8'd255, 8'd128});
      send_colour('{16'd960,   8'd255, 8'd255, 8'd1});
      send_colour('{16'd1919,  8'd200, 8'd180, 8'd2});
      send_colour('{16'd1920,  8'd255, 8'd255, 8'd3});
      send_colour('{16'd2880,  8'd128, 8'd200, 8'd4});
      send_colour('{16'd3840,  8'd255, 8'd255, 8'd5});
      send_colour('{16'd4800,  8'd255, 8'd255, 8'd6});
      send_colour('{16'd5759,  8'd255, 8'd255, 8'd7});
      send_colour('{16'd5760,  8'd255, 8'd255, 8'd8});
      send_colour('{16'd65535, 8'd255, 8'd255, 8'd9});
      send_colour('{16'd480,   8'd255, 8'd255, 8'd10});
      send_colour('{16'd1440,  8'd100, 8'd255, 8'd11});
      send_colour('{16'd3360,  8'd255, 8'd128, 8'd12});
      send_colour('{16'd0,     8'd255, 8'd0,   8'd13});
      send_colour('{16'd2400,  8'd0,   8'd255, 8'd14});
      send_colour('{16'd5280,  8'd1,   8'd254, 8'd15});
      send_colour('{16'd11519, 8'd77,  8'd99,  8'd16});
      send_colour('{16'd65535, 8'd0,   8'd255, 8'd255});
      drain_colours();

      for (int i = 0; i < 500; i++) begin
         c.hue        = random_hue();
         c.saturation = random_byte();
         c.brightness = random_byte();
         c.alpha_in   = random_byte();
         send_colour(c);
         if ((i < 150 || i >= 260) && $urandom_range(0, 99) < 35)
            idle_cycles(1);
         if (i == 350) drain_colours();
      end

      @(negedge clock);
      start <= 1'b0;
      wait_cycles = 0;
      while (sb.pending.size() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (12) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d colours never produced an RGBA item", sb.pending.size());
         sb.mismatches += sb.pending.size();
      end

      $display("Checked %0d RGBA items over directed sector edges, hue wrap and random colours,",
               sb.checked);
      $display("with random start gaps, one gap-free run and one full drain; %0d errors.",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #200us;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- hsv_to_rgba_converter_unit.f -----
sv/hsvc_pkg.sv
sv/hsvc_front.sv
sv/hsvc_queue.sv
sv/hsvc_back.sv
sv/hsv_to_rgba_converter_unit.sv
tb/tb_top.sv
